@@ rtl/wlb_pkg.sv @@
// Shared types and constants for the worker load balancer.
`default_nettype none
package wlb_pkg;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_ASSIGN  = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;
  localparam logic [1:0] REQ_NONE    = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_ASSIGNED = 3'd0;
  localparam logic [2:0] ST_RELEASED = 3'd1;
  localparam logic [2:0] ST_RETIRED  = 3'd2;
  localparam logic [2:0] ST_INACTIVE = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_CLEARED  = 3'd5;

  // Configuration register indexes.
  localparam logic CFG_POOL_MODE  = 1'b0;
  localparam logic CFG_POOL_LIMIT = 1'b1;

  localparam logic [15:0] POOL_LIMIT_RESET = 16'd10;
  localparam logic [15:0] FIXED_DEFAULT    = 16'd10;
  localparam logic [15:0] CAP_DEFAULT      = 16'd1000;
  localparam logic [15:0] LOAD_MAX         = 16'hFFFF;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] worker_index;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  chosen_worker;
    logic [15:0] worker_load;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic setup;
    logic scan;
    logic rel_rd;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic started;
    logic scan_last;
  } stat_t;

endpackage
`default_nettype wire

@@ rtl/wlb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wlb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ rtl/wlb_datapath.sv @@
// Datapath of the worker load balancer: pool state, load scan and result register.
`default_nettype none
module wlb_datapath #(
  parameter int MAX_WORKERS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire wlb_pkg::cmd_t cmd,
  output wlb_pkg::stat_t     stat,
  input  wire wlb_pkg::req_t request,
  input  wire logic          cfg_write,
  input  wire logic          cfg_index,
  input  wire logic [15:0]   cfg_data,
  output logic               done,
  output wlb_pkg::rsp_t      result
);

  localparam int IW = $clog2(MAX_WORKERS);
  localparam int CW = $clog2(MAX_WORKERS + 1);

  // Configuration registers.
  logic        pool_mode;
  logic [15:0] pool_limit;

  // Pool state.
  logic                   started;
  logic                   run_mode;
  logic [15:0]            run_limit;
  logic [MAX_WORKERS-1:0] active;
  logic [MAX_WORKERS-1:0] lvalid;
  logic [CW-1:0]          active_cnt;

  wlb_pkg::req_t req_q;

  // Scan state.
  logic [IW-1:0] scan_cnt;
  logic          cmp_en;
  logic [IW-1:0] cmp_idx;
  logic          found;
  logic [IW-1:0] best_idx;
  logic [15:0]   best_load;
  logic          free_found;
  logic [IW-1:0] free_idx;

  // Load memory.
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic [IW-1:0] rd_addr;
  logic [15:0]   rd_data;

  wlb_ram #(
    .WIDTH(16),
    .DEPTH(MAX_WORKERS)
  ) u_load_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Pool setup values taken from the configuration registers.
  logic [15:0]            fix_lim;
  logic [15:0]            cap_lim;
  logic [CW-1:0]          fix_cnt;
  logic [MAX_WORKERS-1:0] fix_active;
  logic [MAX_WORKERS-1:0] cap_active;

  always_comb begin
    fix_lim = (pool_limit == '0) ? wlb_pkg::FIXED_DEFAULT : pool_limit;
    cap_lim = (pool_limit == '0) ? wlb_pkg::CAP_DEFAULT : pool_limit;
    fix_cnt = (32'(fix_lim) >= MAX_WORKERS) ? CW'(MAX_WORKERS) : CW'(fix_lim);
    for (int i = 0; i < MAX_WORKERS; i++) begin
      fix_active[i] = (CW'(i) < fix_cnt);
    end
    cap_active    = '0;
    cap_active[0] = 1'b1;
  end

  // Compare stage of the scan: a load unit never written since the last clear reads as zero.
  logic [15:0] cmp_load;
  logic        cmp_act;
  logic        take;
  logic        free_take;

  always_comb begin
    cmp_load  = lvalid[cmp_idx] ? rd_data : '0;
    cmp_act   = active[cmp_idx];
    if (!run_mode) begin
      take = cmp_act && (!found || (cmp_load < best_load));
    end else begin
      take = !found && cmp_act && (cmp_load < run_limit);
    end
    free_take = run_mode && !free_found && !cmp_act;
  end

  // Finish logic.
  logic          rel_in_range;
  logic [IW-1:0] rel_idx;
  logic          rel_ok;
  logic [15:0]   rel_load;
  logic [15:0]   rel_new;
  logic          retire;
  logic          asg_hit;
  logic          asg_grow;
  logic [IW-1:0] asg_idx;
  logic [15:0]   asg_base;
  logic [15:0]   asg_new;

  always_comb begin
    rel_in_range = (32'(req_q.worker_index) < MAX_WORKERS);
    rel_idx      = IW'(req_q.worker_index);
    rel_ok       = rel_in_range && active[rel_idx];
    rel_load     = lvalid[rel_idx] ? rd_data : '0;
    rel_new      = (rel_load == '0) ? '0 : rel_load - 16'd1;
    retire       = run_mode && (rel_new == '0) && (active_cnt > CW'(1));
    asg_grow     = !found && free_found;
    asg_hit      = found || free_found;
    asg_idx      = found ? best_idx : free_idx;
    asg_base     = found ? best_load : '0;
    asg_new      = (asg_base == wlb_pkg::LOAD_MAX) ? wlb_pkg::LOAD_MAX : asg_base + 16'd1;
  end

  always_comb begin
    rd_addr = cmd.rel_rd ? rel_idx : scan_cnt;
    wr_en   = 1'b0;
    wr_addr = rel_idx;
    wr_data = rel_new;
    if (cmd.finish) begin
      if (req_q.req_type == wlb_pkg::REQ_ASSIGN) begin
        wr_en   = asg_hit;
        wr_addr = asg_idx;
        wr_data = asg_new;
      end else if (req_q.req_type == wlb_pkg::REQ_RELEASE) begin
        wr_en = rel_ok;
      end
    end
  end

  assign stat.started   = started;
  assign stat.scan_last = (scan_cnt == IW'(MAX_WORKERS - 1));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_mode  <= 1'b0;
      pool_limit <= wlb_pkg::POOL_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        wlb_pkg::CFG_POOL_MODE:  pool_mode  <= cfg_data[0];
        wlb_pkg::CFG_POOL_LIMIT: pool_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request latch and scan registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q <= request;
    end
    if (cmd.scan) begin
      cmp_idx <= scan_cnt;
    end
    if (cmp_en && take) begin
      best_idx  <= cmp_idx;
      best_load <= cmp_load;
    end
    if (cmp_en && free_take) begin
      free_idx <= cmp_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt   <= '0;
      cmp_en     <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else begin
      cmp_en <= cmd.scan;
      if (cmd.accept) begin
        scan_cnt   <= '0;
        found      <= 1'b0;
        free_found <= 1'b0;
      end else begin
        if (cmd.scan) begin
          scan_cnt <= scan_cnt + IW'(1);
        end
        if (cmp_en && take) begin
          found <= 1'b1;
        end
        if (cmp_en && free_take) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  // Pool state.
  always_ff @(posedge clk) begin
    if (rst) begin
      started    <= 1'b0;
      run_mode   <= 1'b0;
      run_limit  <= '0;
      active     <= '0;
      lvalid     <= '0;
      active_cnt <= '0;
    end else if (cmd.setup) begin
      started  <= 1'b1;
      run_mode <= pool_mode;
      lvalid   <= '0;
      if (!pool_mode) begin
        run_limit  <= fix_lim;
        active     <= fix_active;
        active_cnt <= fix_cnt;
      end else begin
        run_limit  <= cap_lim;
        active     <= cap_active;
        active_cnt <= CW'(1);
      end
    end else if (cmd.finish) begin
      case (req_q.req_type)
        wlb_pkg::REQ_ASSIGN: begin
          if (asg_hit) begin
            lvalid[asg_idx] <= 1'b1;
          end
          if (asg_grow) begin
            active[asg_idx] <= 1'b1;
            active_cnt      <= active_cnt + CW'(1);
          end
        end
        wlb_pkg::REQ_RELEASE: begin
          if (rel_ok) begin
            lvalid[rel_idx] <= 1'b1;
            if (retire) begin
              active[rel_idx] <= 1'b0;
              active_cnt      <= active_cnt - CW'(1);
            end
          end
        end
        wlb_pkg::REQ_CLEAR: begin
          lvalid <= '0;
        end
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  wlb_pkg::rsp_t result_next;

  always_comb begin
    result_next.status        = wlb_pkg::ST_INACTIVE;
    result_next.chosen_worker = '0;
    result_next.worker_load   = '0;
    case (req_q.req_type)
      wlb_pkg::REQ_ASSIGN: begin
        if (asg_hit) begin
          result_next.status        = wlb_pkg::ST_ASSIGNED;
          result_next.chosen_worker = 4'(asg_idx);
          result_next.worker_load   = asg_new;
        end else begin
          result_next.status = wlb_pkg::ST_FULL;
        end
      end
      wlb_pkg::REQ_RELEASE: begin
        if (rel_ok) begin
          result_next.chosen_worker = 4'(rel_idx);
          if (retire) begin
            result_next.status = wlb_pkg::ST_RETIRED;
          end else begin
            result_next.status      = wlb_pkg::ST_RELEASED;
            result_next.worker_load = rel_new;
          end
        end
      end
      wlb_pkg::REQ_CLEAR: begin
        result_next.status = wlb_pkg::ST_CLEARED;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/wlb_ctrl.sv @@
// Controller state machine of the worker load balancer.
`default_nettype none
module wlb_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [1:0]     req_type,
  input  wire wlb_pkg::stat_t stat,
  output wlb_pkg::cmd_t       cmd,
  output logic                busy
);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_SETUP     = 6'b000010,
    S_SCAN      = 6'b000100,
    S_SCAN_LAST = 6'b001000,
    S_REL_RD    = 6'b010000,
    S_FINISH    = 6'b100000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] op;

  function automatic state_t op_state(input logic [1:0] code);
    state_t s;
    case (code)
      wlb_pkg::REQ_ASSIGN:  s = S_SCAN;
      wlb_pkg::REQ_RELEASE: s = S_REL_RD;
      default:              s = S_FINISH;
    endcase
    return s;
  endfunction

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (req_type == wlb_pkg::REQ_NONE) begin
            state_next = S_FINISH;
          end else if (!stat.started) begin
            state_next = S_SETUP;
          end else begin
            state_next = op_state(req_type);
          end
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = op_state(op);
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_next = S_SCAN_LAST;
        end
      end
      S_SCAN_LAST: begin
        state_next = S_FINISH;
      end
      S_REL_RD: begin
        cmd.rel_rd = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op <= req_type;
    end
  end

  assign busy = (state != S_IDLE);

endmodule
`default_nettype wire

@@ rtl/worker_load_balancer.sv @@
// Top level of the worker load balancer: controller, datapath and load memory.
`default_nettype none
// The block hands jobs to worker slots and keeps a 16-bit saturating load count
// for each slot. A transaction is taken when start is high while busy is low;
// its single result is registered on result, with done high for exactly one
// cycle, and the receiver cannot stall it. The first assign, release or clear
// sets up the pool from pool_mode and pool_limit, which adds the setup state
// to that transaction; register writes after that have no effect until reset.
// An assign walks all MAX_WORKERS load entries through the one read port of
// the load memory, one entry per cycle with a single comparator, in the scan
// state, then the last-scan and finish states; done is registered from the
// finish state. A release does one read and one write, through the read state
// and the finish state; a clear, or an unused request code, goes from idle
// straight to the finish state. Clearing the loads costs no sweep: each memory
// entry has a valid bit, and an entry whose bit is clear reads as zero load.
module worker_load_balancer #(
  parameter int MAX_WORKERS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire wlb_pkg::req_t request,
  output logic               done,
  output wlb_pkg::rsp_t      result,
  input  wire logic          cfg_write,
  input  wire logic          cfg_index,
  input  wire logic [15:0]   cfg_data
);

  // Command and status between the controller and the datapath.
  wlb_pkg::cmd_t  cmd;
  wlb_pkg::stat_t stat;

  wlb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req_type(request.req_type),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  // The datapath owns the configuration registers, the pool state, the scan
  // registers and the registered result.
  wlb_datapath #(
    .MAX_WORKERS(MAX_WORKERS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .request  (request),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .done     (done),
    .result   (result)
  );

endmodule
`default_nettype wire
